// ===== hw/rtl/scfp_pkg.sv =====
// Package for the summed-checksum frame parser: payload and result structs,
// header layout constants, status and register codes. Depends on nothing.
`timescale 1ns / 1ps

package scfp_pkg;

    // Header field sizes in bytes.
    localparam int ID_BYTES      = 2;
    localparam int TYPE_BYTES    = 1;
    localparam int CMD_BYTES     = 1;
    localparam int SESSION_BYTES = 4;
    localparam int LEN_BYTES     = 2;

    // Byte positions inside a frame.
    localparam int ID_START      = 1;
    localparam int TYPE_START    = ID_START + ID_BYTES;
    localparam int CMD_START     = TYPE_START + TYPE_BYTES;
    localparam int SESSION_START = CMD_START + CMD_BYTES;
    localparam int LEN_START     = SESSION_START + SESSION_BYTES;
    localparam int HDR_BYTES     = LEN_START + LEN_BYTES;
    localparam int MIN_FRAME     = HDR_BYTES + 2;

    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_BYTE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE  = CFG_INDEX_W'(1);
    localparam logic [7:0] HEAD_BYTE_RESET = 8'h61;
    localparam logic [7:0] END_BYTE_RESET  = 8'h16;

    // Frame status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_HEAD  = 3'd2;
    localparam logic [2:0] ST_LEN_ERR   = 3'd3;
    localparam logic [2:0] ST_SUM_ERR   = 3'd4;
    localparam logic [2:0] ST_BAD_END   = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } scfp_in_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic [2:0]  status;
        logic [15:0] node_id;
        logic [7:0]  frame_type;
        logic [7:0]  command;
        logic [31:0] session;
        logic [15:0] payload_len;
    } scfp_out_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] end_byte;
    } scfp_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         running_sum;
        logic [7:0]         sum_before_prev;
        logic [7:0]         prev_byte;
        logic               head_error;
        logic [15:0]        id_acc;
        logic [7:0]         type_acc;
        logic [7:0]         cmd_acc;
        logic [31:0]        session_acc;
        logic [15:0]        len_acc;
    } scfp_state_t;

endpackage

// ===== hw/rtl/scfp_decode.sv =====
// Per-byte decode logic for the frame parser: next frame state and the result.
// Depends on scfp_pkg.
`timescale 1ns / 1ps

module scfp_decode (
    input  scfp_pkg::scfp_state_t state,
    input  scfp_pkg::scfp_in_t    item,
    input  scfp_pkg::scfp_cfg_t   cfg,
    output scfp_pkg::scfp_state_t state_next,
    output scfp_pkg::scfp_out_t   result
);
    import scfp_pkg::*;

    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] offset;
    logic [COUNT_W:0]   size;
    logic [7:0]         b;
    logic               pay;
    logic [2:0]         status;
    scfp_state_t        upd;

    assign pos    = state.byte_count;
    assign b      = item.rx_byte;
    assign offset = pos - COUNT_W'(HDR_BYTES);
    assign size   = {1'b0, pos} + (COUNT_W+1)'(1);

    // Check the head byte or shift the byte into its header field.
    always_comb
    begin
        upd = state;
        priority if (pos == '0)
        begin
            upd.head_error = (b != cfg.head_byte);
        end
        else if (pos < COUNT_W'(TYPE_START))
        begin
            upd.id_acc = 16'({state.id_acc, b});
        end
        else if (pos < COUNT_W'(CMD_START))
        begin
            upd.type_acc = 8'({state.type_acc, b});
        end
        else if (pos < COUNT_W'(SESSION_START))
        begin
            upd.cmd_acc = 8'({state.cmd_acc, b});
        end
        else if (pos < COUNT_W'(LEN_START))
        begin
            upd.session_acc = 32'({state.session_acc, b});
        end
        else if (pos < COUNT_W'(HDR_BYTES))
        begin
            upd.len_acc = 16'({state.len_acc, b});
        end
        else
        begin
            upd.len_acc = state.len_acc;
        end
        upd.sum_before_prev = state.running_sum;
        upd.running_sum     = state.running_sum + b;
        upd.prev_byte       = b;
        upd.byte_count      = (pos != COUNT_MAX) ? pos + COUNT_W'(1) : COUNT_MAX;
    end

    assign pay = (pos >= COUNT_W'(HDR_BYTES)) && (offset < {1'b0, upd.len_acc});

    // Checks in priority order; the first failure sets the status.
    always_comb
    begin
        priority if (size < (COUNT_W+1)'(MIN_FRAME))
            status = ST_SHORT;
        else if (upd.head_error)
            status = ST_BAD_HEAD;
        else if ({2'b00, upd.len_acc} != size - (COUNT_W+1)'(MIN_FRAME))
            status = ST_LEN_ERR;
        else if (state.sum_before_prev != state.prev_byte)
            status = ST_SUM_ERR;
        else if (b != cfg.end_byte)
            status = ST_BAD_END;
        else
            status = ST_OK;
    end

    always_comb
    begin
        result               = '0;
        result.payload_valid = pay;
        result.payload_byte  = pay ? b : 8'h00;
        result.frame_done    = item.last_byte;
        if (item.last_byte)
        begin
            result.status      = status;
            result.node_id     = upd.id_acc;
            result.frame_type  = upd.type_acc;
            result.command     = upd.cmd_acc;
            result.session     = upd.session_acc;
            result.payload_len = upd.len_acc;
        end
    end

    assign state_next = item.last_byte ? scfp_state_t'('0) : upd;

endmodule

// ===== hw/rtl/sum_checked_frame_parser.sv =====
// Top level of the summed-checksum frame parser: byte intake, frame state,
// result register with skid stage, configuration registers. Uses scfp_pkg, scfp_decode.
`timescale 1ns / 1ps

// The parser takes one frame byte per transfer on the rx channel and returns exactly one
// result per byte on the res channel, one byte per clock cycle sustained while res_stall
// stays low. Each byte is decoded in a single registered pass: the frame state and the
// header accumulators are updated and the result is written to the result register, or
// to the skid entry when the result register is held, in the cycle the byte is accepted.
// A skid stage behind the result register lets the block take one more byte after the
// downstream side starts to stall; rx_stall rises only when that skid entry is full.
// Payload bytes come out as they arrive, flagged by payload_valid. The result for the
// byte marked last_byte carries frame_done, the decoded header fields and the status;
// when the status is not OK, payload already delivered for that frame must be dropped
// downstream. Registers head_byte (index 0) and end_byte (index 1) are written over the
// cfg channel, which is always ready; writes to other indexes are ignored. Write them
// only while no frame is in progress.
module sum_checked_frame_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_valid,
    output logic                                rx_stall,
    input  scfp_pkg::scfp_in_t                  rx_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output scfp_pkg::scfp_out_t                 res_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                          cfg_data
);
    import scfp_pkg::*;

    scfp_cfg_t   cfg_reg;
    scfp_state_t state_reg;
    scfp_state_t state_next;
    scfp_out_t   result;

    logic        res_valid_reg;
    logic        res_valid_next;
    scfp_out_t   res_data_reg;
    scfp_out_t   res_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    scfp_out_t   skid_data_reg;
    scfp_out_t   skid_data_next;

    logic        accept;
    logic        take;

    // A byte is taken whenever the skid entry is free.
    assign rx_stall  = skid_valid_reg;
    assign accept    = rx_valid && !skid_valid_reg;
    assign take      = res_valid_reg && !res_stall;
    assign cfg_ready = 1'b1;

    scfp_decode u_decode (
        .state      (state_reg),
        .item       (rx_data),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_byte <= HEAD_BYTE_RESET;
            cfg_reg.end_byte  <= END_BYTE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_HEAD_BYTE)
                cfg_reg.head_byte <= cfg_data;
            else if (cfg_index == CFG_END_BYTE)
                cfg_reg.end_byte <= cfg_data;
        end
    end

    // Frame state advances on every accepted byte and clears after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Result register and skid entry. A new result goes to the result register when it
    // is empty or being drained, otherwise to the skid entry, which refills the result
    // register first once the downstream side takes the pending result.
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_data_next   = res_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!res_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                res_valid_next = 1'b1;
                res_data_next  = result;
            end
            else
            begin
                res_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg  <= res_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The skid entry is only ever filled behind a held result.
    a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry holds a result while the result register is empty");

    // The frame state is cleared after the byte marked last.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx_data.last_byte) |=> (state_reg.byte_count == '0))
        else $error("byte count not cleared after the last byte of a frame");

    // Status is only reported on the result that closes a frame.
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.frame_done) |-> (res_data.status == ST_OK))
        else $error("status set on a result that does not close a frame");

    // A skid transfer into the result register comes only after a completed transfer out.
    a_skid_drains_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && res_stall) |=> skid_valid_reg)
        else $error("skid entry dropped while the output was stalled");

endmodule
